// ----- src/hsvq_pkg.sv -----
// Shared types, codes and constants for the HSV color bin quantizer.
// No dependencies; used by hsvq_sector and hsv_color_bin_quantizer_top.
package hsvq_pkg;

	localparam int unsigned ChanW = 8;
	localparam int unsigned HueW  = 17;	// h*d peaks at 360*255
	localparam int unsigned BinW  = 5;
	localparam int unsigned SecW  = 3;

	// hue base angle codes (base*d term of h*d)
	localparam logic [1:0] BASE_60  = 2'd0;
	localparam logic [1:0] BASE_180 = 2'd1;
	localparam logic [1:0] BASE_300 = 2'd2;

	// sector upper bounds in degrees
	localparam logic [8:0] SEC_WRAP = 9'd327;
	localparam logic [8:0] SEC_B0   = 9'd27;
	localparam logic [8:0] SEC_B1   = 9'd56;
	localparam logic [8:0] SEC_B2   = 9'd159;
	localparam logic [8:0] SEC_B3   = 9'd202;
	localparam logic [8:0] SEC_B4   = 9'd280;

	localparam logic [ChanW-1:0] DARK_MAX = 8'd50;	// 5*mx < 255
	localparam logic [ChanW-1:0] DIM_MAX  = 8'd102;	// mx/255 <= 0.4

	typedef struct packed {
		logic [1:0]       base;
		logic             sub;	// subtract 60*e instead of add
		logic [ChanW-1:0] e;	// mx minus the selected channel
	} hue_term_t;

	typedef struct packed {
		logic       dark;
		logic       grey;
		logic       dim;
		logic       pale;
		logic [3:0] glevel;
	} class_t;

	// floor(10*mx/255) - 1 for mx >= 51
	function automatic logic [3:0] grey_level(input logic [ChanW-1:0] mx);
		logic [3:0] n;
		n = 4'd1;
		if (mx >= 8'd77)  n = n + 4'd1;
		if (mx >= 8'd102) n = n + 4'd1;
		if (mx >= 8'd128) n = n + 4'd1;
		if (mx >= 8'd153) n = n + 4'd1;
		if (mx >= 8'd179) n = n + 4'd1;
		if (mx >= 8'd204) n = n + 4'd1;
		if (mx >= 8'd230) n = n + 4'd1;
		if (mx >= 8'd255) n = n + 4'd1;
		return n;
	endfunction

endpackage

// ----- src/hsvq_sector.sv -----
// Hue sector decision: compares h*d against each bound times d.
// Depends on hsvq_pkg.
module hsvq_sector (
	input  logic [hsvq_pkg::HueW-1:0]  hd,
	input  logic [hsvq_pkg::ChanW-1:0] d,
	output logic [hsvq_pkg::SecW-1:0]  sector
);

	logic [hsvq_pkg::HueW-1:0] dx;
	logic [hsvq_pkg::HueW-1:0] t_wrap, t0, t1, t2, t3, t4;

	assign dx     = {{(hsvq_pkg::HueW-hsvq_pkg::ChanW){1'b0}}, d};
	assign t_wrap = hsvq_pkg::HueW'(dx * hsvq_pkg::SEC_WRAP);
	assign t0     = hsvq_pkg::HueW'(dx * hsvq_pkg::SEC_B0);
	assign t1     = hsvq_pkg::HueW'(dx * hsvq_pkg::SEC_B1);
	assign t2     = hsvq_pkg::HueW'(dx * hsvq_pkg::SEC_B2);
	assign t3     = hsvq_pkg::HueW'(dx * hsvq_pkg::SEC_B3);
	assign t4     = hsvq_pkg::HueW'(dx * hsvq_pkg::SEC_B4);

	always_comb begin
		if (hd > t_wrap || hd <= t0) sector = 3'd0;
		else if (hd <= t1)           sector = 3'd1;
		else if (hd <= t2)           sector = 3'd2;
		else if (hd <= t3)           sector = 3'd3;
		else if (hd <= t4)           sector = 3'd4;
		else                         sector = 3'd5;
	end

endmodule

// ----- src/hsv_color_bin_quantizer_top.sv -----
// HSV color bin quantizer top level: three-stage pipeline, RGB word in, bin word out.
// Depends on hsvq_pkg and hsvq_sector.
//
// Takes one RGB pixel word per cycle, unless in_stall holds it, and returns a color bin 0..26.
// The bin passes through three register stages to the output (throughput 1 word per cycle
// while not stalled). Stage 1 finds max, min, spread and the hue term;
// stage 2 forms h*d and the dark/grey/dim/pale tests; stage 3 picks the hue sector
// and the final bin into the output register. A stalled output word freezes the
// whole pipeline and is passed straight back to in_stall; no word is lost or repeated.
module hsv_color_bin_quantizer_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [hsvq_pkg::ChanW-1:0] red,
	input  logic [hsvq_pkg::ChanW-1:0] green,
	input  logic [hsvq_pkg::ChanW-1:0] blue,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [hsvq_pkg::BinW-1:0]  color_bin
);

	logic adv;

	// stage 1 logic
	logic [hsvq_pkg::ChanW-1:0] mx, mn;
	hsvq_pkg::hue_term_t        term;

	logic                       v_s1;
	logic [hsvq_pkg::ChanW-1:0] mx_s1, d_s1;
	hsvq_pkg::hue_term_t        term_s1;

	// stage 2 logic
	logic [hsvq_pkg::HueW-1:0]  base_d, e60, hd;
	logic [10:0]                d5;
	logic [8:0]                 d2;
	hsvq_pkg::class_t           cls;

	logic                       v_s2;
	logic [hsvq_pkg::HueW-1:0]  hd_s2;
	logic [hsvq_pkg::ChanW-1:0] d_s2;
	hsvq_pkg::class_t           cls_s2;

	// stage 3 logic
	logic [hsvq_pkg::SecW-1:0]  sector;
	logic [hsvq_pkg::BinW-1:0]  bin;

	logic                       v_s3;
	logic [hsvq_pkg::BinW-1:0]  bin_s3;

	assign adv      = !(v_s3 && out_stall);
	assign in_stall = !adv;

	// ---- stage 1: max, min, hue term (ties: red, then green, then blue)
	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx)  mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn)  mn = blue;

		if (red == mx) begin
			if (green == mn) term = '{hsvq_pkg::BASE_300, 1'b0, mx - blue};
			else             term = '{hsvq_pkg::BASE_60,  1'b1, mx - green};
		end else if (green == mx) begin
			if (blue == mn)  term = '{hsvq_pkg::BASE_60,  1'b0, mx - red};
			else             term = '{hsvq_pkg::BASE_180, 1'b1, mx - blue};
		end else begin
			if (red == mn)   term = '{hsvq_pkg::BASE_180, 1'b0, mx - green};
			else             term = '{hsvq_pkg::BASE_300, 1'b1, mx - red};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1   <= mx;
			d_s1    <= mx - mn;
			term_s1 <= term;
		end
	end

	// ---- stage 2: h*d and class tests
	always_comb begin
		case (term_s1.base)
			hsvq_pkg::BASE_60:  base_d = hsvq_pkg::HueW'(d_s1) * 17'd60;
			hsvq_pkg::BASE_180: base_d = hsvq_pkg::HueW'(d_s1) * 17'd180;
			hsvq_pkg::BASE_300: base_d = hsvq_pkg::HueW'(d_s1) * 17'd300;
			default:            base_d = '0;
		endcase
		e60 = hsvq_pkg::HueW'(term_s1.e) * 17'd60;
		// e never exceeds d, so the subtraction stays non-negative
		hd  = term_s1.sub ? base_d - e60 : base_d + e60;

		d5 = {3'b000, d_s1} + {1'b0, d_s1, 2'b00};
		d2 = {d_s1, 1'b0};
		cls.dark   = mx_s1 <= hsvq_pkg::DARK_MAX;
		cls.grey   = d5 < {3'b000, mx_s1};
		cls.dim    = mx_s1 <= hsvq_pkg::DIM_MAX;
		cls.pale   = d2 < {1'b0, mx_s1};
		cls.glevel = hsvq_pkg::grey_level(mx_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hd_s2  <= hd;
			d_s2   <= d_s1;
			cls_s2 <= cls;
		end
	end

	// ---- stage 3: sector and bin
	hsvq_sector u_sector (
		.hd     (hd_s2),
		.d      (d_s2),
		.sector (sector)
	);

	always_comb begin
		if (cls_s2.dark)      bin = 5'd0;
		else if (cls_s2.grey) bin = {1'b0, cls_s2.glevel};
		else if (cls_s2.dim)  bin = {2'b00, sector} + 5'd9;
		else if (cls_s2.pale) bin = {1'b0, sector, 1'b0} + 5'd15;
		else                  bin = {1'b0, sector, 1'b0} + 5'd16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s3 <= bin;
		end
	end

	assign out_valid = v_s3;
	assign color_bin = bin_s3;

endmodule

// ----- test/hsv_color_bin_quantizer_top_test.sv -----
// Testbench for hsv_color_bin_quantizer_top: corner pixels, then random pixel streams
// under four flow-control phases, with each bin checked against a local predictor.
// Depends on hsvq_pkg and the quantizer RTL.
module hsv_color_bin_quantizer_top_test;

	localparam int unsigned CW = hsvq_pkg::ChanW;
	localparam int unsigned BW = hsvq_pkg::BinW;

	typedef struct {
		logic [CW-1:0] r;
		logic [CW-1:0] g;
		logic [CW-1:0] b;
		logic [BW-1:0] bin;
	} pixel_bin_t;

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          in_valid  = 1'b0;
	logic          in_stall;
	logic [CW-1:0] red       = '0;
	logic [CW-1:0] green     = '0;
	logic [CW-1:0] blue      = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [BW-1:0] color_bin;

	pixel_bin_t pending_bins[$];
	int         idle_pct  = 0;
	int         stall_pct = 0;
	int         errors    = 0;
	int         checked   = 0;
	bit         bin_hit[27];

	hsv_color_bin_quantizer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.color_bin (color_bin)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout, %0d words still pending", $time, pending_bins.size());
		$display("FAILURE");
		$finish;
	end

	// hexcone hue kept as h*d, all thresholds cross-multiplied
	function automatic logic [BW-1:0] quantize_pixel(input logic [CW-1:0] r, g, b);
		int ri, gi, bi, mx, mn, d, hd, sector, bin;
		ri = int'(r);
		gi = int'(g);
		bi = int'(b);
		mx = (ri > gi) ? ri : gi;
		mx = (bi > mx) ? bi : mx;
		mn = (ri < gi) ? ri : gi;
		mn = (bi < mn) ? bi : mn;
		d  = mx - mn;
		if (5 * mx < 255) begin
			bin = 0;
		end else if (5 * d < mx) begin
			bin = (10 * mx) / 255 - 1;
		end else begin
			if (ri == mx) begin
				hd = (gi == mn) ? 300 * d + 60 * (mx - bi) : 60 * d - 60 * (mx - gi);
			end else if (gi == mx) begin
				hd = (bi == mn) ? 60 * d + 60 * (mx - ri) : 180 * d - 60 * (mx - bi);
			end else begin
				hd = (ri == mn) ? 180 * d + 60 * (mx - gi) : 300 * d - 60 * (mx - ri);
			end
			if (hd > 327 * d || hd <= 27 * d) sector = 0;
			else if (hd <= 56 * d)  sector = 1;
			else if (hd <= 159 * d) sector = 2;
			else if (hd <= 202 * d) sector = 3;
			else if (hd <= 280 * d) sector = 4;
			else                    sector = 5;
			if (mx <= 102)       bin = sector + 9;
			else if (2 * d < mx) bin = 2 * sector + 15;
			else                 bin = 2 * sector + 16;
		end
		return bin[BW-1:0];
	endfunction

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		pixel_bin_t exp_word;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bins.size() == 0) begin
				errors++;
				$display("%0t: result word %0d with nothing pending", $time, color_bin);
			end else begin
				exp_word = pending_bins.pop_front();
				checked++;
				if (color_bin !== exp_word.bin) begin
					errors++;
					$display("%0t: rgb %0d,%0d,%0d expected bin %0d, got %0d", $time,
						exp_word.r, exp_word.g, exp_word.b, exp_word.bin, color_bin);
				end else begin
					bin_hit[exp_word.bin] = 1'b1;
				end
			end
		end
	end

	// caller is at a rising edge; returns at the edge the word is taken
	task automatic send_pixel(input logic [CW-1:0] r, g, b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		do @(posedge clk); while (in_stall);
		pending_bins.push_back('{r, g, b, quantize_pixel(r, g, b)});
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_bins.size() != 0);
	endtask

	task automatic test_corner_pixels();
		send_pixel(8'd0,   8'd0,   8'd0);	// black
		send_pixel(8'd255, 8'd255, 8'd255);	// white, top grey level
		send_pixel(8'd50,  8'd0,   8'd0);	// last dark
		send_pixel(8'd51,  8'd0,   8'd0);	// first non-dark, dim
		send_pixel(8'd102, 8'd0,   8'd0);	// dim edge
		send_pixel(8'd103, 8'd0,   8'd0);	// first bright
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd255, 8'd205, 8'd205);	// grey just under saturation 0.2
		send_pixel(8'd255, 8'd204, 8'd204);	// saturation exactly 0.2
		send_pixel(8'd255, 8'd128, 8'd128);	// pale
		send_pixel(8'd254, 8'd127, 8'd127);	// saturation exactly 0.5
		send_pixel(8'd200, 8'd200, 8'd100);	// red/green tie on max
		send_pixel(8'd100, 8'd200, 8'd200);	// green/blue tie
		send_pixel(8'd200, 8'd100, 8'd200);	// red/blue tie
		send_pixel(8'd255, 8'd0,   8'd128);	// hue wraps past 327
		send_pixel(8'd255, 8'd0,   8'd200);
		send_pixel(8'd77,  8'd77,  8'd77);
		send_pixel(8'd76,  8'd76,  8'd76);
		send_pixel(8'd170, 8'd85,  8'd85);
	endtask

	task automatic test_random_pixels(input int count, input int send_idle, input int rx_stall);
		int hi, lo, mid, d, pick;
		logic [CW-1:0] r, g, b;
		idle_pct  = send_idle;
		stall_pct = rx_stall;
		for (int i = 0; i < count; i++) begin
			hi = $urandom_range(255);
			lo = $urandom_range(hi);
			pick = $urandom_range(9);
			if (pick >= 3 && pick <= 4) begin
				lo = hi - $urandom_range(hi / 4);	// near-grey
			end else if (pick >= 5 && pick <= 7) begin
				case ($urandom_range(7))
					0: hi = 50;
					1: hi = 51;
					2: hi = 102;
					3: hi = 103;
					4: hi = 254;
					5: hi = 255;
					default: ;
				endcase
				case ($urandom_range(3))
					0: d = hi / 5 + $urandom_range(2) - 1;
					1: d = (hi + 1) / 2 + $urandom_range(2) - 1;
					2: d = hi;
					default: d = $urandom_range(hi);
				endcase
				if (d < 0) d = 0;
				if (d > hi) d = hi;
				lo = hi - d;
			end
			mid = $urandom_range(hi, lo);
			if (pick >= 8) mid = $urandom_range(1) ? hi : lo;
			if (pick <= 2) begin
				r = CW'($urandom_range(255));
				g = CW'($urandom_range(255));
				b = CW'($urandom_range(255));
			end else begin
				case ($urandom_range(5))
					0: begin r = CW'(hi);  g = CW'(mid); b = CW'(lo);  end
					1: begin r = CW'(hi);  g = CW'(lo);  b = CW'(mid); end
					2: begin r = CW'(mid); g = CW'(hi);  b = CW'(lo);  end
					3: begin r = CW'(lo);  g = CW'(hi);  b = CW'(mid); end
					4: begin r = CW'(mid); g = CW'(lo);  b = CW'(hi);  end
					default: begin r = CW'(lo); g = CW'(mid); b = CW'(hi); end
				endcase
			end
			send_pixel(r, g, b);
		end
	endtask

	task automatic test_drain_and_resume();
		idle_pct  = 0;
		stall_pct = 30;
		wait_drain();
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd10,  8'd20, 8'd30);
		send_pixel(8'd128, 8'd64, 8'd32);
		wait_drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_corner_pixels();
		test_random_pixels(440, 0, 0);
		test_random_pixels(440, 58, 0);
		test_drain_and_resume();
		test_random_pixels(440, 0, 58);
		test_random_pixels(440, 19, 19);
		stall_pct = 0;
		wait_drain();
		repeat (8) @(posedge clk);
		$display("Checked %0d pixel words over steady, sender-idle, receiver-stall and mixed flow.",
			checked);
		$display("Bins matched at least once: %0d of 27.", bin_hit.sum() with (int'(item)));
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- hsv_color_bin_quantizer_top.f -----
src/hsvq_pkg.sv
src/hsvq_sector.sv
src/hsv_color_bin_quantizer_top.sv
test/hsv_color_bin_quantizer_top_test.sv
